### design/assert_macros.svh
// Assertion macros used by the top level of the pileup base counter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### design/pbc_pkg.sv
// Types, constants and helper functions of the pileup base counter.
package pbc_pkg;

	localparam int COUNT_WIDTH = 32;
	localparam int NUM_COUNTS  = 7;

	localparam int IX_A      = 0;
	localparam int IX_T      = 1;
	localparam int IX_G      = 2;
	localparam int IX_C      = 3;
	localparam int IX_INS    = 4;
	localparam int IX_DEL    = 5;
	localparam int IX_PASSED = 6;

	typedef enum logic [2:0] {
		CMD_LOCUS  = 3'd0,
		CMD_HEADER = 3'd1,
		CMD_CIGAR  = 3'd2,
		CMD_BASE   = 3'd3,
		CMD_END    = 3'd4
	} cmd_t;

	localparam logic [3:0] OP_M = 4'd0;
	localparam logic [3:0] OP_I = 4'd1;
	localparam logic [3:0] OP_D = 4'd2;
	localparam logic [3:0] OP_S = 4'd4;

	localparam logic [3:0] BASE_A = 4'd1;
	localparam logic [3:0] BASE_C = 4'd2;
	localparam logic [3:0] BASE_G = 4'd4;
	localparam logic [3:0] BASE_T = 4'd8;

	localparam logic REG_MIN_MAPQ   = 1'b0;
	localparam logic REG_FLAG_LIMIT = 1'b1;

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [NUM_COUNTS-1:0][COUNT_WIDTH-1:0] count_vec_t;

	typedef struct packed {
		cmd_t        command;
		logic [30:0] position;
		logic [7:0]  mapq;
		logic [15:0] flag_word;
		logic [3:0]  cigar_op;
		logic [27:0] cigar_len;
		logic [3:0]  base_code;
	} item_t;

	typedef struct packed {
		logic [7:0]  min_mapq;
		logic [15:0] flag_limit;
	} cfg_t;

	function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic logic [31:0] report32(input count_t c);
		logic [COUNT_WIDTH+31:0] wide;
		logic [COUNT_WIDTH+31:0] lim;
		wide = {32'b0, c};
		lim  = {{COUNT_WIDTH{1'b0}}, 32'hFFFF_FFFF};
		return (wide > lim) ? 32'hFFFF_FFFF : wide[31:0];
	endfunction

endpackage

### design/pileup_base_counter.sv
// Top level of the pileup base counter: input register, result register, config.
// Timing: a transaction is registered into item_s1 on acceptance and processed from there;
//   the result of an end-locus transaction is registered into result_q when it fires.
// Throughput: one transaction per cycle, except while an end-locus transaction waits on a stalled result.
// Reset: arst_n clears all walk state and counters, min_mapq to 0, flag_limit to 65535.
`include "assert_macros.svh"
module pileup_base_counter
	import pbc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  command,
	input  logic [30:0] position,
	input  logic [7:0]  mapq,
	input  logic [15:0] flag_word,
	input  logic [3:0]  cigar_op,
	input  logic [27:0] cigar_len,
	input  logic [3:0]  base_code,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] a_count,
	output logic [31:0] t_count,
	output logic [31:0] g_count,
	output logic [31:0] c_count,
	output logic [31:0] ins_count,
	output logic [31:0] del_count,
	output logic [31:0] reads_passed
);

	cfg_t       cfg_q;
	item_t      item_s1;
	logic       valid_s1;
	logic       fire_s1;
	logic       end_s1;
	logic       out_free;
	logic       out_valid_q;
	count_vec_t counts;
	logic [NUM_COUNTS-1:0][31:0] result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_mapq   <= 8'd0;
			cfg_q.flag_limit <= 16'hFFFF;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_MIN_MAPQ:   cfg_q.min_mapq   <= cfg_data[7:0];
				REG_FLAG_LIMIT: cfg_q.flag_limit <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign end_s1   = (item_s1.command == CMD_END);
	assign fire_s1  = valid_s1 && (!end_s1 || out_free);
	assign in_stall = valid_s1 && !fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// hold the payload while stalled
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.command   <= cmd_t'(command);
			item_s1.position  <= position;
			item_s1.mapq      <= mapq;
			item_s1.flag_word <= flag_word;
			item_s1.cigar_op  <= cigar_op;
			item_s1.cigar_len <= cigar_len;
			item_s1.base_code <= base_code;
		end
	end

	pbc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire_s1),
		.item   (item_s1),
		.cfg    (cfg_q),
		.counts (counts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && end_s1) begin
			for (int i = 0; i < NUM_COUNTS; i++) begin
				result_q[i] <= report32(counts[i]);
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign a_count      = result_q[IX_A];
	assign t_count      = result_q[IX_T];
	assign g_count      = result_q[IX_G];
	assign c_count      = result_q[IX_C];
	assign ins_count    = result_q[IX_INS];
	assign del_count    = result_q[IX_DEL];
	assign reads_passed = result_q[IX_PASSED];

	`ASSERT_NEXT(a_end_emits, clk, arst_n, fire_s1 && end_s1, out_valid, "end transaction gave no result")
	`ASSERT_NEXT(a_no_spurious, clk, arst_n, !out_valid_q && !(fire_s1 && end_s1), !out_valid, "result without end transaction")
	`ASSERT_IMPLIES(a_stall_cause, clk, arst_n, in_stall, valid_s1 && end_s1 && out_valid_q && out_stall, "input stalled without a blocked result")

endmodule

### design/pbc_core.sv
// Read walk state and saturating counters of the pileup base counter.
module pbc_core
	import pbc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  item_t      item,
	input  cfg_t       cfg,
	output count_vec_t counts
);

	logic [30:0]           target_q;
	logic [31:0]           ref_pos_q;
	logic [31:0]           read_idx_q;
	logic [31:0]           wanted_idx_q;
	logic [31:0]           base_counter_q;
	logic                  active_q;
	logic                  resolved_q;
	logic                  want_q;
	count_vec_t            counts_q;

	logic [30:0]           target_d;
	logic [31:0]           ref_pos_d;
	logic [31:0]           read_idx_d;
	logic [31:0]           wanted_idx_d;
	logic [31:0]           base_counter_d;
	logic                  active_d;
	logic                  resolved_d;
	logic                  want_d;
	logic [NUM_COUNTS-1:0] bump_en;
	logic                  clear_counts;

	always_comb begin
		logic [31:0] tgt;
		logic [31:0] len;
		logic [31:0] ri_n;
		logic [31:0] rp_n;
		logic [31:0] back;
		tgt            = {1'b0, target_q};
		len            = {4'b0, item.cigar_len};
		ri_n           = read_idx_q;
		rp_n           = ref_pos_q;
		back           = '0;
		target_d       = target_q;
		ref_pos_d      = ref_pos_q;
		read_idx_d     = read_idx_q;
		wanted_idx_d   = wanted_idx_q;
		base_counter_d = base_counter_q;
		active_d       = active_q;
		resolved_d     = resolved_q;
		want_d         = want_q;
		bump_en        = '0;
		clear_counts   = 1'b0;
		if (fire) begin
			unique case (item.command)
				CMD_LOCUS: begin
					target_d       = item.position;
					ref_pos_d      = '0;
					read_idx_d     = '0;
					wanted_idx_d   = '0;
					base_counter_d = '0;
					active_d       = 1'b0;
					resolved_d     = 1'b0;
					want_d         = 1'b0;
					clear_counts   = 1'b1;
				end
				CMD_HEADER: begin
					ref_pos_d      = '0;
					read_idx_d     = '0;
					wanted_idx_d   = '0;
					base_counter_d = '0;
					active_d       = 1'b0;
					resolved_d     = 1'b0;
					want_d         = 1'b0;
					if (item.mapq > cfg.min_mapq && item.flag_word < cfg.flag_limit) begin
						bump_en[IX_PASSED] = 1'b1;
						active_d           = 1'b1;
						ref_pos_d          = {1'b0, item.position};
					end
				end
				CMD_CIGAR: begin
					if (active_q && !resolved_q) begin
						if (item.cigar_op == OP_M) begin
							ri_n = sat_add32(read_idx_q, len);
							rp_n = sat_add32(ref_pos_q, len);
						end else if (item.cigar_op == OP_S || item.cigar_op == OP_I) begin
							ri_n = sat_add32(read_idx_q, len);
						end else if (item.cigar_op == OP_D) begin
							rp_n = sat_add32(ref_pos_q, len);
						end
						read_idx_d = ri_n;
						ref_pos_d  = rp_n;
						if (rp_n > tgt) begin
							if (item.cigar_op == OP_M && ref_pos_q <= tgt) begin
								back         = rp_n - tgt;
								wanted_idx_d = (ri_n >= back) ? ri_n - back : '0;
								want_d       = 1'b1;
							end
							resolved_d = 1'b1;
						end else if (rp_n == tgt) begin
							if (item.cigar_op == OP_I) begin
								bump_en[IX_INS] = 1'b1;
								resolved_d      = 1'b1;
							end else if (item.cigar_op == OP_D) begin
								bump_en[IX_DEL] = 1'b1;
								resolved_d      = 1'b1;
							end
						end
					end
				end
				CMD_BASE: begin
					if (active_q) begin
						if (want_q && base_counter_q == wanted_idx_q) begin
							bump_en[IX_A] = (item.base_code == BASE_A);
							bump_en[IX_T] = (item.base_code == BASE_T);
							bump_en[IX_G] = (item.base_code == BASE_G);
							bump_en[IX_C] = (item.base_code == BASE_C);
							want_d        = 1'b0;
						end
						base_counter_d = sat_add32(base_counter_q, 32'd1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q       <= '0;
			ref_pos_q      <= '0;
			read_idx_q     <= '0;
			wanted_idx_q   <= '0;
			base_counter_q <= '0;
			active_q       <= 1'b0;
			resolved_q     <= 1'b0;
			want_q         <= 1'b0;
			counts_q       <= '0;
		end else begin
			target_q       <= target_d;
			ref_pos_q      <= ref_pos_d;
			read_idx_q     <= read_idx_d;
			wanted_idx_q   <= wanted_idx_d;
			base_counter_q <= base_counter_d;
			active_q       <= active_d;
			resolved_q     <= resolved_d;
			want_q         <= want_d;
			for (int i = 0; i < NUM_COUNTS; i++) begin
				if (clear_counts) begin
					counts_q[i] <= '0;
				end else if (bump_en[i] && counts_q[i] != {COUNT_WIDTH{1'b1}}) begin
					counts_q[i] <= counts_q[i] + count_t'(1);
				end
			end
		end
	end

	assign counts = counts_q;

endmodule

### test/tb_pileup_base_counter.sv
// Self-checking testbench of the pileup base counter: directed table, random reads, back-pressure.
module tb_pileup_base_counter;
	import pbc_pkg::*;

	localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
	localparam int SETTLE_CYCLES  = 4;
	localparam int QUIET_LIMIT    = 4000;
	localparam int HOLD_CYCLES    = 400;
	localparam int ITEM_GOAL      = 1200;
	localparam int REPORT_GOAL    = 40;
	localparam logic [27:0] MAX_LEN = 28'hFFFFFFF;
	localparam int SHOWN_MISMATCH = 10;

	typedef struct packed {
		logic [2:0]  command;
		logic [30:0] position;
		logic [7:0]  mapq;
		logic [15:0] flag_word;
		logic [3:0]  cigar_op;
		logic [27:0] cigar_len;
		logic [3:0]  base_code;
	} pile_item_t;

	typedef struct {
		pile_item_t item;
		bit         typed;
		count_vec_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic cfg_index = 1'b0;
	logic [15:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] command = '0;
	logic [30:0] position = '0;
	logic [7:0] mapq = '0;
	logic [15:0] flag_word = '0;
	logic [3:0] cigar_op = '0;
	logic [27:0] cigar_len = '0;
	logic [3:0] base_code = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [31:0] a_count;
	logic [31:0] t_count;
	logic [31:0] g_count;
	logic [31:0] c_count;
	logic [31:0] ins_count;
	logic [31:0] del_count;
	logic [31:0] reads_passed;

	pileup_base_counter i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.position(position),
		.mapq(mapq),
		.flag_word(flag_word),
		.cigar_op(cigar_op),
		.cigar_len(cigar_len),
		.base_code(base_code),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.a_count(a_count),
		.t_count(t_count),
		.g_count(g_count),
		.c_count(c_count),
		.ins_count(ins_count),
		.del_count(del_count),
		.reads_passed(reads_passed)
	);

	// predicted block state
	logic [7:0]  cfg_min_mapq = 8'd0;
	logic [15:0] cfg_flag_limit = 16'hFFFF;
	logic [30:0] p_target = '0;
	logic [31:0] p_ref = '0;
	logic [31:0] p_read_idx = '0;
	logic [31:0] p_wanted = '0;
	logic [31:0] p_bases = '0;
	bit p_active = 1'b0;
	bit p_resolved = 1'b0;
	bit p_want = 1'b0;
	count_t p_tally [NUM_COUNTS] = '{default: '0};

	count_vec_t reports_due [$];
	dir_row_t dir_rows [$];
	string field_names [NUM_COUNTS] = '{"a_count", "t_count", "g_count", "c_count",
		"ins_count", "del_count", "reads_passed"};

	int fails = 0;
	int items_sent = 0;
	int ends_sent = 0;
	int quiet = 0;
	int hold_pending = 0;
	bit rush = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [31:0] clamp_add(input logic [31:0] a, input logic [31:0] b);
		return (a > ~b) ? 32'hFFFF_FFFF : a + b;
	endfunction

	function automatic pile_item_t rand_item();
		logic [95:0] raw;
		raw = {$urandom(), $urandom(), $urandom()};
		return raw[93:0];
	endfunction

	task automatic bump_tally(input int ix);
		if (p_tally[ix] != '1)
			p_tally[ix] = p_tally[ix] + 1'b1;
	endtask

	task automatic drop_read();
		p_ref = '0;
		p_read_idx = '0;
		p_wanted = '0;
		p_bases = '0;
		p_active = 1'b0;
		p_resolved = 1'b0;
		p_want = 1'b0;
	endtask

	task automatic tally_item(input pile_item_t it, output bit emits, output count_vec_t rep);
		logic [31:0] prior;
		logic [31:0] back;
		logic [31:0] len;
		logic [63:0] wide;
		emits = 1'b0;
		rep = '0;
		len = {4'b0, it.cigar_len};
		case (it.command)
			CMD_LOCUS: begin
				p_target = it.position;
				drop_read();
				foreach (p_tally[i])
					p_tally[i] = '0;
			end
			CMD_HEADER: begin
				drop_read();
				if (it.mapq > cfg_min_mapq && it.flag_word < cfg_flag_limit) begin
					bump_tally(IX_PASSED);
					p_active = 1'b1;
					p_ref = {1'b0, it.position};
				end
			end
			CMD_CIGAR: begin
				if (p_active && !p_resolved) begin
					prior = p_ref;
					case (it.cigar_op)
						OP_M: begin
							p_read_idx = clamp_add(p_read_idx, len);
							p_ref = clamp_add(p_ref, len);
						end
						OP_S, OP_I: begin
							p_read_idx = clamp_add(p_read_idx, len);
						end
						OP_D: begin
							p_ref = clamp_add(p_ref, len);
						end
						default: ;
					endcase
					if (p_ref > {1'b0, p_target}) begin
						if (it.cigar_op == OP_M && prior <= {1'b0, p_target}) begin
							back = p_ref - {1'b0, p_target};
							p_wanted = (p_read_idx >= back) ? p_read_idx - back : '0;
							p_want = 1'b1;
						end
						p_resolved = 1'b1;
					end else if (p_ref == {1'b0, p_target}) begin
						if (it.cigar_op == OP_I) begin
							bump_tally(IX_INS);
							p_resolved = 1'b1;
						end else if (it.cigar_op == OP_D) begin
							bump_tally(IX_DEL);
							p_resolved = 1'b1;
						end
					end
				end
			end
			CMD_BASE: begin
				if (p_active) begin
					if (p_want && p_bases == p_wanted) begin
						case (it.base_code)
							BASE_A: bump_tally(IX_A);
							BASE_T: bump_tally(IX_T);
							BASE_G: bump_tally(IX_G);
							BASE_C: bump_tally(IX_C);
							default: ;
						endcase
						p_want = 1'b0;
					end
					p_bases = clamp_add(p_bases, 32'd1);
				end
			end
			CMD_END: begin
				emits = 1'b1;
				for (int i = 0; i < NUM_COUNTS; i++) begin
					wide = 64'(p_tally[i]);
					rep[i] = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
				end
			end
			default: ;
		endcase
	endtask

	task automatic log_mismatch(input string msg);
		fails++;
		if (fails <= SHOWN_MISMATCH)
			$display("%0t: %s", $realtime, msg);
	endtask

	task automatic send_item(input pile_item_t it, input bit typed, input count_vec_t want);
		int gap;
		bit emits;
		count_vec_t rep;
		gap = rush ? 0 : $urandom_range(0, 15);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		command <= it.command;
		position <= it.position;
		mapq <= it.mapq;
		flag_word <= it.flag_word;
		cigar_op <= it.cigar_op;
		cigar_len <= it.cigar_len;
		base_code <= it.base_code;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		items_sent++;
		tally_item(it, emits, rep);
		if (emits) begin
			ends_sent++;
			reports_due.push_back(typed ? want : rep);
		end
	endtask

	task automatic send_cmd(input logic [2:0] cmd);
		pile_item_t it;
		it = rand_item();
		it.command = cmd;
		send_item(it, 1'b0, '0);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (reports_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_MIN_MAPQ)
			cfg_min_mapq = val[7:0];
		else
			cfg_flag_limit = val;
	endtask

	task automatic add_row(input logic [2:0] cmd, input logic [30:0] pos, input logic [7:0] mq,
			input logic [15:0] flg, input logic [3:0] op, input logic [27:0] len,
			input logic [3:0] code);
		dir_row_t row;
		row.item = '{cmd, pos, mq, flg, op, len, code};
		row.typed = 1'b0;
		row.want = '0;
		dir_rows.push_back(row);
	endtask

	task automatic send_base();
		pile_item_t it;
		it = rand_item();
		it.command = CMD_BASE;
		if ($urandom_range(0, 7) != 0)
			it.base_code = 4'b0001 << $urandom_range(0, 3);
		send_item(it, 1'b0, '0);
	endtask

	task automatic send_read(input logic [30:0] tgt);
		pile_item_t it;
		int off;
		int pick;
		it = rand_item();
		it.command = CMD_HEADER;
		off = $urandom_range(0, 40);
		if ($urandom_range(0, 11) != 0)
			it.position = (tgt > 31'(off)) ? tgt - 31'(off) : '0;
		if ($urandom_range(0, 9) < 8) begin
			it.mapq = (cfg_min_mapq == 8'hFF) ? 8'hFF : 8'($urandom_range(cfg_min_mapq + 1, 255));
			it.flag_word = (cfg_flag_limit == 0) ? '0 : 16'($urandom_range(0, cfg_flag_limit - 1));
		end
		send_item(it, 1'b0, '0);
		repeat ($urandom_range(1, 6)) begin
			if ($urandom_range(0, 5) == 0)
				send_base();
			it = rand_item();
			it.command = CMD_CIGAR;
			pick = $urandom_range(0, 15);
			if (pick < 7)
				it.cigar_op = OP_M;
			else if (pick < 9)
				it.cigar_op = OP_I;
			else if (pick < 11)
				it.cigar_op = OP_D;
			else if (pick < 13)
				it.cigar_op = OP_S;
			if ($urandom_range(0, 19) != 0)
				it.cigar_len = 28'($urandom_range(0, 24));
			send_item(it, 1'b0, '0);
		end
		repeat ($urandom_range(0, 32))
			send_base();
	endtask

	always begin
		int w;
		do
			@(posedge clk);
		while (arst_n !== 1'b1);
		forever begin
			w = (hold_pending > 0) ? hold_pending : (rush ? 0 : $urandom_range(0, 15));
			hold_pending = 0;
			if (w > 0) begin
				@(negedge clk);
				out_stall <= 1'b1;
				repeat (w - 1) @(negedge clk);
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do
				@(posedge clk);
			while (out_valid !== 1'b1);
		end
	end

	always @(posedge clk) begin
		count_vec_t seen;
		count_vec_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			seen[IX_A] = a_count;
			seen[IX_T] = t_count;
			seen[IX_G] = g_count;
			seen[IX_C] = c_count;
			seen[IX_INS] = ins_count;
			seen[IX_DEL] = del_count;
			seen[IX_PASSED] = reads_passed;
			if (reports_due.size() == 0) begin
				log_mismatch($sformatf("unexpected count report, a_count %0d", a_count));
			end else begin
				want = reports_due.pop_front();
				for (int i = 0; i < NUM_COUNTS; i++)
					if (seen[i] !== want[i])
						log_mismatch($sformatf("%s: expected %0d got %0d",
							field_names[i], want[i], seen[i]));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)))
			quiet = 0;
		else if (arst_n)
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("pileup_base_counter test failed");
			$finish;
		end
	end

	initial begin
		pile_item_t it;
		logic [30:0] tgt;
		logic [7:0] mq;
		logic [15:0] lim;
		int phase;

		add_row(CMD_END, 31'd0, 8'd0, 16'd0, OP_M, 28'd0, 4'd0);
		dir_rows[0].typed = 1'b1;
		add_row(CMD_LOCUS, 31'd1000, 8'd0, 16'd0, OP_M, 28'd0, 4'd0);
		add_row(CMD_HEADER, 31'd1000, 8'd1, 16'd0, OP_M, 28'd0, 4'd0);
		add_row(CMD_CIGAR, 31'd0, 8'd0, 16'd0, OP_M, 28'd1, 4'd0);
		add_row(CMD_BASE, 31'd0, 8'd0, 16'd0, OP_M, 28'd0, BASE_A);
		add_row(CMD_BASE, 31'd0, 8'd0, 16'd0, OP_M, 28'd0, BASE_T);
		add_row(CMD_HEADER, 31'd999, 8'd255, 16'd65534, OP_M, 28'd0, 4'd0);
		add_row(CMD_CIGAR, 31'd0, 8'd0, 16'd0, OP_M, 28'd1, 4'd0);
		add_row(CMD_CIGAR, 31'd0, 8'd0, 16'd0, OP_I, 28'd3, 4'd0);
		add_row(CMD_CIGAR, 31'd0, 8'd0, 16'd0, OP_M, 28'd5, 4'd0);
		add_row(CMD_HEADER, 31'd990, 8'd10, 16'd0, OP_M, 28'd0, 4'd0);
		add_row(CMD_CIGAR, 31'd0, 8'd0, 16'd0, OP_D, 28'd10, 4'd0);
		add_row(CMD_HEADER, 31'd1000, 8'd0, 16'd0, OP_M, 28'd0, 4'd0);
		add_row(CMD_CIGAR, 31'd0, 8'd0, 16'd0, OP_M, MAX_LEN, 4'd0);
		add_row(CMD_HEADER, 31'd1000, 8'd255, 16'd65535, OP_M, 28'd0, 4'd0);
		add_row(CMD_HEADER, 31'd1001, 8'd50, 16'd0, OP_M, 28'd0, 4'd0);
		add_row(CMD_CIGAR, 31'd0, 8'd0, 16'd0, OP_M, 28'd1, 4'd0);
		add_row(CMD_HEADER, 31'd0, 8'd200, 16'd1, OP_M, 28'd0, 4'd0);
		add_row(CMD_CIGAR, 31'd0, 8'd0, 16'd0, 4'd15, 28'd5, 4'd0);
		add_row(CMD_BASE, 31'd0, 8'd0, 16'd0, OP_M, 28'd0, BASE_C);
		add_row(CMD_CIGAR, 31'd0, 8'd0, 16'd0, OP_S, MAX_LEN, 4'd0);
		add_row(CMD_CIGAR, 31'd0, 8'd0, 16'd0, OP_M, MAX_LEN, 4'd0);
		add_row(CMD_BASE, 31'd0, 8'd0, 16'd0, OP_M, 28'd0, 4'd0);
		add_row(CMD_SPARE_FIRST, 31'h7FFFFFFF, 8'hFF, 16'hFFFF, 4'hF, MAX_LEN, 4'hF);
		add_row(CMD_SPARE_LAST, 31'd0, 8'd0, 16'd0, OP_M, 28'd0, 4'd0);
		add_row(CMD_END, 31'd0, 8'd0, 16'd0, OP_M, 28'd0, 4'd0);
		add_row(CMD_LOCUS, 31'h7FFFFFFF, 8'd0, 16'd0, OP_M, 28'd0, 4'd0);
		add_row(CMD_HEADER, 31'h7FFFFFFF, 8'd255, 16'd0, OP_M, 28'd0, 4'd0);
		add_row(CMD_CIGAR, 31'd0, 8'd0, 16'd0, OP_D, 28'd0, 4'd0);
		add_row(CMD_END, 31'd0, 8'd0, 16'd0, OP_M, 28'd0, 4'd0);

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[k])
			send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);

		// hold the result side while a burst of end-locus transactions piles up
		wait_drained();
		rush = 1'b1;
		hold_pending = HOLD_CYCLES;
		send_cmd(CMD_LOCUS);
		repeat (30) begin
			send_cmd(CMD_END);
			send_base();
		end
		wait_drained();
		rush = 1'b0;

		phase = 0;
		while (items_sent < ITEM_GOAL || ends_sent < REPORT_GOAL) begin
			wait_drained();
			case (phase % 4)
				0: begin
					mq = 8'd0;
					lim = 16'hFFFF;
				end
				1: begin
					mq = 8'hFF;
					lim = 16'hFFFF;
				end
				2: begin
					mq = 8'd0;
					lim = 16'd0;
				end
				default: begin
					mq = 8'($urandom);
					lim = 16'($urandom);
				end
			endcase
			write_reg(REG_MIN_MAPQ, {8'($urandom), mq});
			write_reg(REG_FLAG_LIMIT, lim);
			rush = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(2, 4)) begin
				it = rand_item();
				it.command = CMD_LOCUS;
				if ($urandom_range(0, 3) != 0)
					it.position = 31'($urandom_range(0, 3000));
				tgt = it.position;
				send_item(it, 1'b0, '0);
				repeat ($urandom_range(1, 5)) begin
					send_read(tgt);
					if ($urandom_range(0, 2) == 0)
						send_cmd(CMD_END);
					if ($urandom_range(0, 7) == 0)
						send_item(rand_item(), 1'b0, '0);
				end
				send_cmd(CMD_END);
			end
			phase++;
		end

		wait_drained();
		if (fails == 0 && reports_due.size() == 0)
			$display("pileup_base_counter test passed");
		else
			$display("pileup_base_counter test failed");
		$finish;
	end

endmodule
